[rtl/core/suffix_array_lcp_builder_assert.svh]
// assertion helpers shared by the rtl
`ifndef SUFFIX_ARRAY_LCP_BUILDER_ASSERT_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_ASSERT_SVH

// same-cycle implication
`define SAL_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define SAL_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/core/sal_pkg.sv]
`timescale 1ns / 1ps
package sal_pkg;
	localparam int MAX_LEN_DEF = 1024;
	localparam int CMD_W = 2;
	localparam int SYM_W = 8;
	localparam int IDX_W = 11;
	localparam int SYM_MAX = 255;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic KIND_BUILD = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;
endpackage

[rtl/core/sal_in_if.sv]
`timescale 1ns / 1ps
interface sal_in_if;
	logic                      valid;
	logic                      ready;
	logic [sal_pkg::CMD_W-1:0] cmd;
	logic [sal_pkg::SYM_W-1:0] symbol;
	logic [sal_pkg::IDX_W-1:0] rank_index;

	modport source(output valid, cmd, symbol, rank_index, input ready);
	modport sink(input valid, cmd, symbol, rank_index, output ready);
endinterface

[rtl/core/sal_out_if.sv]
`timescale 1ns / 1ps
interface sal_out_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [sal_pkg::IDX_W-1:0] start_position;
	logic [sal_pkg::IDX_W-1:0] common_prefix;
	logic [sal_pkg::IDX_W-1:0] text_length;
	logic                      status;

	modport source(output valid, kind, start_position, common_prefix, text_length, status,
		input ready);
	modport sink(input valid, kind, start_position, common_prefix, text_length, status,
		output ready);
endinterface

[rtl/core/sal_ram.sv]
`timescale 1ns / 1ps
module sal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/suffix_array_lcp_builder.sv]
// Suffix array and LCP builder. Load transactions append one text symbol
// (1 to 255) each; symbol 0 and loads past MAX_LEN are dropped. A build
// transaction sorts all suffixes by prefix doubling with counting sorts and
// then runs a Kasai pass for the LCP of each suffix with its predecessor; it
// answers with one kind 0 result. Read transactions return the start and LCP
// at a sorted rank (1 up to the text length), or status 1 when out of range.
// A read answers in the next cycle; input waits while a result is stalled.
// A build of n symbols is run by a sequencer around memories with one write
// port and one read port each and registered reads: a setup step, a counting
// sort over K+1 buckets (K = max(255, distinct ranks)), then doubling passes
// of key generation, a counting sort, a swap and re-ranking, at most
// ceil(log2 n) + 1 passes, and a Kasai pass whose work grows with the total
// LCP extension steps. The input is held off while a build runs.
`timescale 1ns / 1ps
`include "suffix_array_lcp_builder_assert.svh"
module suffix_array_lcp_builder #(
	parameter int MAX_LEN = sal_pkg::MAX_LEN_DEF
) (
	input logic          clk,
	input logic          arst_n,
	sal_in_if.sink       item,
	sal_out_if.source    result
);
	localparam int PW    = $clog2(MAX_LEN + 1);
	localparam int KMAX  = (MAX_LEN > sal_pkg::SYM_MAX) ? MAX_LEN : sal_pkg::SYM_MAX;
	localparam int CD    = KMAX + 1;
	localparam int RW    = $clog2(CD);
	localparam int JW    = PW + 1;
	localparam int SW    = PW + 2;
	localparam int DEPTH = MAX_LEN + 1;
	localparam int CW    = (PW > sal_pkg::IDX_W) ? PW : sal_pkg::IDX_W;
	localparam logic [RW-1:0] SYM_KMAX = RW'(sal_pkg::SYM_MAX);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_INIT_A = 5'd1;
	localparam logic [4:0] S_INIT_B = 5'd2;
	localparam logic [4:0] S_CLR    = 5'd3;
	localparam logic [4:0] S_CNT_A  = 5'd4;
	localparam logic [4:0] S_CNT_B  = 5'd5;
	localparam logic [4:0] S_CNT_C  = 5'd6;
	localparam logic [4:0] S_PRE_A  = 5'd7;
	localparam logic [4:0] S_PRE_B  = 5'd8;
	localparam logic [4:0] S_DST_A  = 5'd9;
	localparam logic [4:0] S_DST_B  = 5'd10;
	localparam logic [4:0] S_DST_C  = 5'd11;
	localparam logic [4:0] S_DST_D  = 5'd12;
	localparam logic [4:0] S_PASS   = 5'd13;
	localparam logic [4:0] S_G1     = 5'd14;
	localparam logic [4:0] S_G2_A   = 5'd15;
	localparam logic [4:0] S_G2_B   = 5'd16;
	localparam logic [4:0] S_SWP_A  = 5'd17;
	localparam logic [4:0] S_SWP_B  = 5'd18;
	localparam logic [4:0] S_REN_A  = 5'd19;
	localparam logic [4:0] S_REN_B  = 5'd20;
	localparam logic [4:0] S_REN_C  = 5'd21;
	localparam logic [4:0] S_REN_D  = 5'd22;
	localparam logic [4:0] S_LCP_A  = 5'd23;
	localparam logic [4:0] S_LCP_B  = 5'd24;
	localparam logic [4:0] S_LCP_C  = 5'd25;
	localparam logic [4:0] S_LCP_D  = 5'd26;
	localparam logic [4:0] S_LCP_E  = 5'd27;
	localparam logic [4:0] S_DONE   = 5'd28;

	logic [4:0]    st_q;
	logic [RW-1:0] i_q;
	logic [PW-1:0] cnt_q;
	logic [RW-1:0] p_q;
	logic [JW-1:0] j_q;
	logic [RW-1:0] kmax_q;
	logic [PW-1:0] acc_q;
	logic [PW-1:0] pos_q;
	logic [RW-1:0] k_q;
	logic [PW-1:0] x_q;
	logic [RW-1:0] pa_q;
	logic [RW-1:0] pb_q;
	logic [RW-1:0] a_q;
	logic [RW-1:0] r_q;
	logic [PW-1:0] q_q;
	logic [PW-1:0] h_q;
	logic          pass_q;

	logic                      v_s1;
	logic                      kind_s1;
	logic                      status_s1;
	logic [PW-1:0]             len_s1;
	logic [sal_pkg::IDX_W-1:0] idx_s1;

	// memory ports
	logic          tx_we;
	logic [PW-1:0] tx_wa;
	logic [sal_pkg::SYM_W-1:0] tx_wd, txa_rd, txb_rd;
	logic [PW-1:0] txa_ra, txb_ra;
	logic          sa_we, lc_we, rk_we, sk_we, cn_we;
	logic [PW-1:0] sa_wa, sa_wd, sa_ra, sa_rd;
	logic [PW-1:0] lc_wa, lc_wd, lc_ra, lc_rd;
	logic [PW-1:0] rk_wa, rk_ra, sk_wa, sk_ra;
	logic [RW-1:0] rk_wd, rk_rd, sk_wd, sk_rd;
	logic [RW-1:0] cn_wa, cn_ra;
	logic [PW-1:0] cn_wd, cn_rd;

	logic          acc;
	logic          load_ok;
	logic          idx_ok;
	logic [RW-1:0] n_r;
	logic [PW-1:0] i_p;
	logic          i_last;
	logic [SW-1:0] xj;
	logic          xj_in;
	logic [RW-1:0] b_nx;
	logic          same;
	logic [RW-1:0] rank_nx;
	logic [PW-1:0] from_v;
	logic [PW-1:0] h_dec;
	logic [JW-1:0] ih;
	logic [JW-1:0] qh;
	logic          ext_ok;
	logic          r_bad;
	logic [PW-1:0] idx_p;

	assign acc     = item.valid && item.ready;
	assign item.ready = (st_q == S_IDLE) && (!v_s1 || result.ready);
	assign load_ok = (item.symbol != '0) && (cnt_q != PW'(MAX_LEN));
	assign idx_ok  = (item.rank_index != '0) && (CW'(item.rank_index) <= CW'(cnt_q));
	assign idx_p   = PW'(item.rank_index);
	assign n_r     = RW'(cnt_q);
	assign i_p     = PW'(i_q);
	assign i_last  = (i_q == n_r);
	assign xj      = SW'(x_q) + SW'(j_q);
	assign xj_in   = (xj <= SW'(cnt_q));
	assign b_nx    = xj_in ? sk_rd : '0;
	assign same    = (i_q != RW'(1)) && (a_q == pa_q) && (b_nx == pb_q);
	assign rank_nx = same ? p_q : p_q + RW'(1);
	assign from_v  = (j_q >= JW'(cnt_q)) ? PW'(1) : cnt_q - PW'(j_q) + PW'(1);
	assign h_dec   = (h_q != '0) ? h_q - PW'(1) : '0;
	assign ih      = JW'(i_p) + JW'(h_q);
	assign qh      = JW'(q_q) + JW'(h_q);
	assign ext_ok  = (ih <= JW'(cnt_q)) && (qh <= JW'(cnt_q));
	assign r_bad   = (rk_rd <= RW'(1)) || (rk_rd > n_r);

	// memory address and write control
	always_comb begin
		tx_we  = acc && (item.cmd == sal_pkg::CMD_LOAD) && load_ok;
		tx_wa  = cnt_q + PW'(1);
		tx_wd  = item.symbol;
		txa_ra = i_p;
		txb_ra = '0;
		sa_we  = 1'b0;
		sa_wa  = PW'(cn_rd);
		sa_wd  = pos_q;
		sa_ra  = (acc && (item.cmd == sal_pkg::CMD_READ)) ? idx_p : PW'(idx_s1);
		lc_we  = 1'b0;
		lc_wa  = PW'(r_q);
		lc_wd  = h_q;
		lc_ra  = sa_ra;
		rk_we  = 1'b0;
		rk_wa  = i_p;
		rk_wd  = sk_rd;
		rk_ra  = i_p;
		sk_we  = 1'b0;
		sk_wa  = i_p;
		sk_wd  = rk_rd;
		sk_ra  = i_p;
		cn_we  = 1'b0;
		cn_wa  = i_q;
		cn_wd  = '0;
		cn_ra  = i_q;
		case (st_q)
			S_INIT_B: begin
				rk_we = 1'b1;
				rk_wd = RW'(txa_rd);
				sk_we = 1'b1;
				sk_wd = i_q;
			end
			S_CLR: begin
				cn_we = 1'b1;
			end
			S_CNT_B: begin
				cn_ra = rk_rd;
			end
			S_CNT_C: begin
				cn_we = 1'b1;
				cn_wa = k_q;
				cn_wd = cn_rd + PW'(1);
			end
			S_PRE_B: begin
				cn_we = 1'b1;
				cn_wd = acc_q + cn_rd;
			end
			S_DST_B: begin
				rk_ra = PW'(sk_rd);
			end
			S_DST_C: begin
				cn_ra = rk_rd;
			end
			S_DST_D: begin
				sa_we = 1'b1;
				cn_we = 1'b1;
				cn_wa = k_q;
				cn_wd = cn_rd - PW'(1);
			end
			S_G1: begin
				sk_we = 1'b1;
				sk_wa = PW'(p_q + RW'(1));
				sk_wd = i_q;
			end
			S_G2_A: begin
				sa_ra = i_p;
			end
			S_G2_B: begin
				sk_we = (JW'(sa_rd) > j_q);
				sk_wa = PW'(p_q + RW'(1));
				sk_wd = RW'(JW'(sa_rd) - j_q);
			end
			S_SWP_B: begin
				sk_we = 1'b1;
				rk_we = 1'b1;
			end
			S_REN_A: begin
				sa_ra = i_p;
			end
			S_REN_B: begin
				sk_ra = sa_rd;
			end
			S_REN_C: begin
				sk_ra = PW'(xj);
			end
			S_REN_D: begin
				rk_we = 1'b1;
				rk_wa = x_q;
				rk_wd = rank_nx;
			end
			S_LCP_B: begin
				sa_ra = PW'(rk_rd - RW'(1));
				lc_we = (rk_rd == RW'(1));
				lc_wa = PW'(1);
				lc_wd = '0;
			end
			S_LCP_D: begin
				txa_ra = PW'(ih);
				txb_ra = PW'(qh);
				lc_we  = !ext_ok;
			end
			S_LCP_E: begin
				lc_we = (txa_rd != txb_rd);
			end
			default: begin
			end
		endcase
	end

	// sequencer and result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			i_q       <= '0;
			cnt_q     <= '0;
			p_q       <= '0;
			j_q       <= '0;
			kmax_q    <= '0;
			acc_q     <= '0;
			pos_q     <= '0;
			k_q       <= '0;
			x_q       <= '0;
			pa_q      <= '0;
			pb_q      <= '0;
			a_q       <= '0;
			r_q       <= '0;
			q_q       <= '0;
			h_q       <= '0;
			pass_q    <= 1'b0;
			v_s1      <= 1'b0;
			kind_s1   <= sal_pkg::KIND_BUILD;
			status_s1 <= sal_pkg::STATUS_OK;
			len_s1    <= '0;
			idx_s1    <= '0;
		end else begin
			if (v_s1 && result.ready) begin
				v_s1 <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						case (item.cmd)
							sal_pkg::CMD_LOAD: begin
								if (load_ok) begin
									cnt_q <= cnt_q + PW'(1);
								end
							end
							sal_pkg::CMD_BUILD: begin
								kmax_q <= SYM_KMAX;
								j_q    <= JW'(1);
								pass_q <= 1'b0;
								i_q    <= RW'(1);
								st_q   <= (cnt_q == '0) ? S_DONE : S_INIT_A;
							end
							sal_pkg::CMD_READ: begin
								v_s1      <= 1'b1;
								kind_s1   <= sal_pkg::KIND_READ;
								status_s1 <= idx_ok ? sal_pkg::STATUS_OK : sal_pkg::STATUS_RANGE;
								len_s1    <= cnt_q;
								idx_s1    <= item.rank_index;
							end
							default: begin
							end
						endcase
					end
				end
				S_INIT_A: st_q <= S_INIT_B;
				S_INIT_B: begin
					if (i_last) begin
						i_q  <= '0;
						st_q <= S_CLR;
					end else begin
						i_q  <= i_q + RW'(1);
						st_q <= S_INIT_A;
					end
				end
				S_CLR: begin
					if (i_q == kmax_q) begin
						i_q  <= RW'(1);
						st_q <= S_CNT_A;
					end else begin
						i_q <= i_q + RW'(1);
					end
				end
				S_CNT_A: st_q <= S_CNT_B;
				S_CNT_B: begin
					k_q  <= rk_rd;
					st_q <= S_CNT_C;
				end
				S_CNT_C: begin
					if (i_last) begin
						i_q   <= '0;
						acc_q <= '0;
						st_q  <= S_PRE_A;
					end else begin
						i_q  <= i_q + RW'(1);
						st_q <= S_CNT_A;
					end
				end
				S_PRE_A: st_q <= S_PRE_B;
				S_PRE_B: begin
					acc_q <= acc_q + cn_rd;
					if (i_q == kmax_q) begin
						i_q  <= n_r;
						st_q <= S_DST_A;
					end else begin
						i_q  <= i_q + RW'(1);
						st_q <= S_PRE_A;
					end
				end
				S_DST_A: st_q <= S_DST_B;
				S_DST_B: begin
					pos_q <= PW'(sk_rd);
					st_q  <= S_DST_C;
				end
				S_DST_C: begin
					k_q  <= rk_rd;
					st_q <= S_DST_D;
				end
				S_DST_D: begin
					if (i_q == RW'(1)) begin
						st_q <= pass_q ? S_SWP_A : S_PASS;
					end else begin
						i_q  <= i_q - RW'(1);
						st_q <= S_DST_A;
					end
				end
				S_PASS: begin
					i_q    <= RW'(from_v);
					p_q    <= '0;
					pass_q <= 1'b1;
					st_q   <= S_G1;
				end
				S_G1: begin
					p_q <= p_q + RW'(1);
					if (i_last) begin
						i_q  <= RW'(1);
						st_q <= S_G2_A;
					end else begin
						i_q <= i_q + RW'(1);
					end
				end
				S_G2_A: st_q <= S_G2_B;
				S_G2_B: begin
					if (JW'(sa_rd) > j_q) begin
						p_q <= p_q + RW'(1);
					end
					if (i_last) begin
						i_q  <= '0;
						st_q <= S_CLR;
					end else begin
						i_q  <= i_q + RW'(1);
						st_q <= S_G2_A;
					end
				end
				S_SWP_A: st_q <= S_SWP_B;
				S_SWP_B: begin
					if (i_last) begin
						i_q  <= RW'(1);
						p_q  <= '0;
						st_q <= S_REN_A;
					end else begin
						i_q  <= i_q + RW'(1);
						st_q <= S_SWP_A;
					end
				end
				S_REN_A: st_q <= S_REN_B;
				S_REN_B: begin
					x_q  <= sa_rd;
					st_q <= S_REN_C;
				end
				S_REN_C: begin
					a_q  <= sk_rd;
					st_q <= S_REN_D;
				end
				S_REN_D: begin
					p_q  <= rank_nx;
					pa_q <= a_q;
					pb_q <= b_nx;
					if (i_last) begin
						kmax_q <= (rank_nx > SYM_KMAX) ? rank_nx : SYM_KMAX;
						if (rank_nx < n_r) begin
							j_q  <= j_q << 1;
							st_q <= S_PASS;
						end else begin
							i_q  <= RW'(1);
							h_q  <= '0;
							st_q <= S_LCP_A;
						end
					end else begin
						i_q  <= i_q + RW'(1);
						st_q <= S_REN_A;
					end
				end
				S_LCP_A: st_q <= S_LCP_B;
				S_LCP_B: begin
					r_q <= rk_rd;
					if (r_bad) begin
						h_q <= '0;
						if (i_last) begin
							st_q <= S_DONE;
						end else begin
							i_q  <= i_q + RW'(1);
							st_q <= S_LCP_A;
						end
					end else begin
						h_q  <= h_dec;
						st_q <= S_LCP_C;
					end
				end
				S_LCP_C: begin
					q_q  <= sa_rd;
					st_q <= S_LCP_D;
				end
				S_LCP_D: begin
					if (ext_ok) begin
						st_q <= S_LCP_E;
					end else if (i_last) begin
						st_q <= S_DONE;
					end else begin
						i_q  <= i_q + RW'(1);
						st_q <= S_LCP_A;
					end
				end
				S_LCP_E: begin
					if (txa_rd == txb_rd) begin
						h_q  <= h_q + PW'(1);
						st_q <= S_LCP_D;
					end else if (i_last) begin
						st_q <= S_DONE;
					end else begin
						i_q  <= i_q + RW'(1);
						st_q <= S_LCP_A;
					end
				end
				S_DONE: begin
					v_s1      <= 1'b1;
					kind_s1   <= sal_pkg::KIND_BUILD;
					status_s1 <= sal_pkg::STATUS_OK;
					len_s1    <= cnt_q;
					st_q      <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid          = v_s1;
	assign result.kind           = kind_s1;
	assign result.status         = status_s1;
	assign result.text_length    = sal_pkg::IDX_W'(len_s1);
	assign result.start_position = (kind_s1 == sal_pkg::KIND_READ && status_s1 == sal_pkg::STATUS_OK)
		? sal_pkg::IDX_W'(sa_rd) : '0;
	assign result.common_prefix  = (kind_s1 == sal_pkg::KIND_READ && status_s1 == sal_pkg::STATUS_OK)
		? sal_pkg::IDX_W'(lc_rd) : '0;

	// text is kept twice so the lcp scan reads both suffixes in the same cycle
	sal_ram #(.WIDTH(sal_pkg::SYM_W), .DEPTH(DEPTH)) u_txt_a (
		.clk(clk), .we(tx_we), .waddr(tx_wa), .wdata(tx_wd), .raddr(txa_ra), .rdata(txa_rd)
	);
	sal_ram #(.WIDTH(sal_pkg::SYM_W), .DEPTH(DEPTH)) u_txt_b (
		.clk(clk), .we(tx_we), .waddr(tx_wa), .wdata(tx_wd), .raddr(txb_ra), .rdata(txb_rd)
	);
	sal_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_sa (
		.clk(clk), .we(sa_we), .waddr(sa_wa), .wdata(sa_wd), .raddr(sa_ra), .rdata(sa_rd)
	);
	sal_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_lcp (
		.clk(clk), .we(lc_we), .waddr(lc_wa), .wdata(lc_wd), .raddr(lc_ra), .rdata(lc_rd)
	);
	sal_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_rank (
		.clk(clk), .we(rk_we), .waddr(rk_wa), .wdata(rk_wd), .raddr(rk_ra), .rdata(rk_rd)
	);
	sal_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_skey (
		.clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd)
	);
	sal_ram #(.WIDTH(PW), .DEPTH(CD)) u_bucket (
		.clk(clk), .we(cn_we), .waddr(cn_wa), .wdata(cn_wd), .raddr(cn_ra), .rdata(cn_rd)
	);

	`SAL_ASSERT_IMP(a_build_quiet, st_q != S_IDLE && st_q != S_DONE, !v_s1, "result pending in build")
	`SAL_ASSERT_IMP(a_bucket_floor, st_q == S_DST_D, cn_rd != '0, "bucket count underflow")
	`SAL_ASSERT_IMP(a_rank_bound, st_q == S_REN_D, rank_nx <= n_r, "rank above text length")
	`SAL_ASSERT_IMP(a_lcp_bound, st_q == S_LCP_D, h_q <= cnt_q, "lcp above text length")
	`SAL_ASSERT_NXT(a_done_rsp, st_q == S_DONE, v_s1 && kind_s1 == sal_pkg::KIND_BUILD, "no build result")
endmodule

[tb/tb_suffix_array_lcp_builder.sv]
`timescale 1ns / 1ps
module tb_suffix_array_lcp_builder;
	localparam int TEXT_MAX = 1024;
	localparam int BUCKETS = TEXT_MAX + 257;
	localparam logic [sal_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 8000000;

	typedef struct packed {
		logic                      kind;
		logic [sal_pkg::IDX_W-1:0] start_position;
		logic [sal_pkg::IDX_W-1:0] common_prefix;
		logic [sal_pkg::IDX_W-1:0] text_length;
		logic                      status;
	} answer_t;

	logic clk;
	logic arst_n;
	sal_in_if in_ch();
	sal_out_if out_ch();

	suffix_array_lcp_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(in_ch),
		.result(out_ch)
	);

	answer_t answer_q[$];
	int mismatches;
	longint cycles;
	bit idle_on;
	int hold_cycles;

	int text_sym[0:TEXT_MAX+1];
	int suffix_at[0:TEXT_MAX+1];
	int rank_at[0:TEXT_MAX+1];
	int order_tmp[0:TEXT_MAX+1];
	int lcp_at[0:TEXT_MAX+1];
	int bucket[0:BUCKETS-1];
	int text_len;
	int built_len;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function void bucket_sort(int n, int keymax);
		int i;
		int p;
		int k;
		for (i = 0; i < BUCKETS; i++) bucket[i] = 0;
		for (i = 1; i <= n; i++) bucket[rank_at[i]]++;
		for (i = 1; i <= keymax; i++) bucket[i] += bucket[i-1];
		for (i = n; i >= 1; i--) begin
			p = order_tmp[i];
			k = rank_at[p];
			suffix_at[bucket[k]] = p;
			bucket[k]--;
		end
	endfunction

	function int prev_rank(int pos, int n);
		if (pos == 0 || pos > n) return 0;
		return order_tmp[pos];
	endfunction

	function void build_suffixes();
		int n;
		int i;
		int j;
		int p;
		int keymax;
		int from;
		int t;
		int x;
		int y;
		int h;
		int r;
		int q;
		bit same;
		n = text_len;
		if (n == 0) return;
		for (i = 1; i <= n; i++) begin
			order_tmp[i] = i;
			rank_at[i] = text_sym[i];
		end
		keymax = sal_pkg::SYM_MAX;
		bucket_sort(n, keymax);
		suffix_at[0] = 0;
		p = 0;
		for (j = 1; p < n; j = j << 1) begin
			from = (j >= n) ? 1 : n - j + 1;
			p = 0;
			for (i = from; i <= n; i++) order_tmp[++p] = i;
			for (i = 1; i <= n; i++)
				if (suffix_at[i] > j) order_tmp[++p] = suffix_at[i] - j;
			bucket_sort(n, keymax);
			for (i = 1; i <= n; i++) begin
				t = order_tmp[i];
				order_tmp[i] = rank_at[i];
				rank_at[i] = t;
			end
			p = 0;
			for (i = 1; i <= n; i++) begin
				x = suffix_at[i];
				same = 0;
				if (i > 1) begin
					y = suffix_at[i-1];
					same = prev_rank(x, n) == prev_rank(y, n) &&
						prev_rank(x + j, n) == prev_rank(y + j, n);
				end
				if (!same) p++;
				rank_at[x] = p;
			end
			keymax = (p > sal_pkg::SYM_MAX) ? p : sal_pkg::SYM_MAX;
		end
		h = 0;
		for (i = 1; i <= n; i++) begin
			r = rank_at[i];
			if (h > 0) h--;
			if (r <= 1 || r > n) begin
				h = 0;
				if (r == 1) lcp_at[1] = 0;
			end else begin
				q = suffix_at[r-1];
				while (i + h <= n && q + h <= n && text_sym[i+h] == text_sym[q+h]) h++;
				lcp_at[r] = h;
			end
		end
	endfunction

	function void predict(logic [sal_pkg::CMD_W-1:0] cmd, logic [sal_pkg::SYM_W-1:0] sym,
		logic [sal_pkg::IDX_W-1:0] idx);
		answer_t a;
		a = '0;
		a.text_length = sal_pkg::IDX_W'(text_len);
		case (cmd)
			sal_pkg::CMD_LOAD: begin
				if (sym != 0 && text_len < TEXT_MAX) begin
					text_len++;
					text_sym[text_len] = int'(sym);
				end
			end
			sal_pkg::CMD_BUILD: begin
				build_suffixes();
				built_len = text_len;
				a.kind = sal_pkg::KIND_BUILD;
				a.status = sal_pkg::STATUS_OK;
				answer_q.push_back(a);
			end
			sal_pkg::CMD_READ: begin
				a.kind = sal_pkg::KIND_READ;
				if (idx == 0 || idx > text_len) begin
					a.status = sal_pkg::STATUS_RANGE;
				end else begin
					a.status = sal_pkg::STATUS_OK;
					a.start_position = sal_pkg::IDX_W'(suffix_at[idx]);
					a.common_prefix = sal_pkg::IDX_W'(lcp_at[idx]);
				end
				answer_q.push_back(a);
			end
			default: ;
		endcase
	endfunction

	task send(logic [sal_pkg::CMD_W-1:0] cmd, logic [sal_pkg::SYM_W-1:0] sym,
		logic [sal_pkg::IDX_W-1:0] idx);
		int gap;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.symbol <= sym;
		in_ch.rank_index <= idx;
		do @(posedge clk); while (!in_ch.ready);
		predict(cmd, sym, idx);
	endtask

	task drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (answer_q.size() != 0) @(posedge clk);
	endtask

	// receiver side: random gaps plus an optional long hold-off
	initial begin
		int gap;
		gap = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) gap = idle_on ? $urandom_range(0, 7) : 0;
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.kind, out_ch.start_position, out_ch.common_prefix,
				out_ch.text_length, out_ch.status};
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: kind %0d start %0d lcp %0d len %0d st %0d",
						got.kind, got.start_position, got.common_prefix,
						got.text_length, got.status);
			end else begin
				want = answer_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp kind %0d start %0d lcp %0d len %0d st %0d, got kind %0d start %0d lcp %0d len %0d st %0d",
							want.kind, want.start_position, want.common_prefix,
							want.text_length, want.status, got.kind,
							got.start_position, got.common_prefix, got.text_length,
							got.status);
				end
			end
		end
	end

	task read_random();
		int r;
		r = $urandom_range(0, 9);
		if (built_len > 0 && r < 7)
			send(sal_pkg::CMD_READ, sal_pkg::SYM_W'($urandom),
				sal_pkg::IDX_W'($urandom_range(1, built_len)));
		else if (r == 7)
			send(sal_pkg::CMD_READ, sal_pkg::SYM_W'($urandom), '0);
		else
			send(sal_pkg::CMD_READ, sal_pkg::SYM_W'($urandom),
				sal_pkg::IDX_W'($urandom_range(text_len + 1, 2047)));
	endtask

	task test_empty_text();
		send(sal_pkg::CMD_READ, 8'd0, 11'd0);
		send(sal_pkg::CMD_READ, 8'd0, 11'd1);
		send(sal_pkg::CMD_BUILD, 8'd0, 11'd0);
		send(CMD_UNUSED, 8'hff, 11'h7ff);
	endtask

	task test_directed_small();
		int i;
		send(sal_pkg::CMD_LOAD, 8'd0, 11'd0);
		send(sal_pkg::CMD_LOAD, 8'd255, 11'd0);
		send(sal_pkg::CMD_LOAD, 8'd1, 11'd0);
		send(sal_pkg::CMD_LOAD, 8'd1, 11'h7ff);
		send(sal_pkg::CMD_LOAD, 8'd255, 11'd0);
		send(sal_pkg::CMD_LOAD, 8'd1, 11'd0);
		send(sal_pkg::CMD_LOAD, 8'd1, 11'd0);
		send(sal_pkg::CMD_BUILD, 8'd0, 11'd0);
		for (i = 0; i <= built_len + 1; i++)
			send(sal_pkg::CMD_READ, 8'd0, sal_pkg::IDX_W'(i));
		send(sal_pkg::CMD_READ, 8'hff, 11'h7ff);
		send(CMD_UNUSED, 8'd0, 11'd0);
		drain();
	endtask

	task test_random_texts(int items);
		int sent;
		int k;
		int alpha;
		sent = 0;
		while (sent < items) begin
			idle_on = ($urandom_range(0, 3) != 0);
			alpha = $urandom_range(0, 2);
			k = $urandom_range(0, 8);
			repeat (k) begin
				if (text_len < 120) begin
					if ($urandom_range(0, 15) == 0)
						send(sal_pkg::CMD_LOAD, 8'd0, sal_pkg::IDX_W'($urandom));
					else if (alpha == 0)
						send(sal_pkg::CMD_LOAD, sal_pkg::SYM_W'($urandom_range(1, 2)),
							sal_pkg::IDX_W'($urandom));
					else if (alpha == 1)
						send(sal_pkg::CMD_LOAD, sal_pkg::SYM_W'($urandom_range(1, 4)),
							sal_pkg::IDX_W'($urandom));
					else
						send(sal_pkg::CMD_LOAD, sal_pkg::SYM_W'($urandom_range(1, 255)),
							sal_pkg::IDX_W'($urandom));
					sent++;
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				send(sal_pkg::CMD_BUILD, sal_pkg::SYM_W'($urandom), sal_pkg::IDX_W'($urandom));
				sent++;
			end
			k = $urandom_range(1, 8);
			repeat (k) begin
				if ($urandom_range(0, 19) == 0)
					send(CMD_UNUSED, sal_pkg::SYM_W'($urandom), sal_pkg::IDX_W'($urandom));
				else read_random();
				sent++;
			end
		end
		drain();
	endtask

	task test_output_stall();
		idle_on = 0;
		hold_cycles = 300;
		repeat (40) read_random();
		drain();
		idle_on = 1;
	endtask

	task test_full_text();
		int i;
		while (text_len < TEXT_MAX)
			send(sal_pkg::CMD_LOAD, sal_pkg::SYM_W'($urandom_range(1, 255)),
				sal_pkg::IDX_W'($urandom));
		send(sal_pkg::CMD_LOAD, 8'd7, 11'd0);
		send(sal_pkg::CMD_LOAD, 8'd0, 11'd0);
		send(sal_pkg::CMD_BUILD, 8'd0, 11'd0);
		send(sal_pkg::CMD_READ, 8'd0, 11'd1);
		send(sal_pkg::CMD_READ, 8'd0, 11'd1024);
		send(sal_pkg::CMD_READ, 8'd0, 11'd1025);
		for (i = 0; i < 20; i++) read_random();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = sal_pkg::CMD_LOAD;
		in_ch.symbol = '0;
		in_ch.rank_index = '0;
		mismatches = 0;
		hold_cycles = 0;
		idle_on = 1;
		text_len = 0;
		built_len = 0;
		for (int i = 0; i <= TEXT_MAX + 1; i++) begin
			text_sym[i] = 0;
			suffix_at[i] = 0;
			rank_at[i] = 0;
			order_tmp[i] = 0;
			lcp_at[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_text();
		test_directed_small();
		test_output_stall();
		test_random_texts(250);
		test_output_stall();
		test_full_text();
		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && answer_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sal_pkg.sv
rtl/core/sal_in_if.sv
rtl/core/sal_out_if.sv
rtl/core/sal_ram.sv
rtl/core/suffix_array_lcp_builder.sv
tb/tb_suffix_array_lcp_builder.sv
